// ----- rtl/core/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge, and skip it while reset is applied.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check a property on every rising clk edge, including edges during reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/tdts_pkg.sv -----
package tdts_pkg;

	localparam int unsigned SLOT_COUNT    = 8;
	localparam int unsigned TASK_W        = 3;
	localparam int unsigned DELAY_W       = 8;
	localparam int unsigned TICK_W        = 8;
	localparam int unsigned NUM_TASKS_DEF = 8;

	typedef enum logic [1:0] {
		KIND_TICK    = 2'd0,
		KIND_SLEEP   = 2'd1,
		KIND_SUSPEND = 2'd2,
		KIND_PICK    = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [DELAY_W-1:0] delay_ticks;
	} req_t;

	typedef struct packed {
		logic [TASK_W-1:0]     chosen_task;
		logic                  task_found;
		logic [SLOT_COUNT-1:0] ready_mask;
	} rsp_t;

	// Per-event controls that the top level broadcasts to every cell.
	typedef struct packed {
		logic               tick;
		logic               load;
		logic               clear;
		logic               pick;
		logic [DELAY_W-1:0] delay;
	} cell_ev_t;

endpackage

// ----- rtl/core/tick_delay_task_scheduler_top.sv -----
// Channel | Direction | Word  | Handshake
// req     | in        | req_t | req_valid / req_stall
// rsp     | out       | rsp_t | rsp_valid / rsp_stall
//
// Each event is applied to the cells and its result word is registered at the
// same edge, so a new event can enter every cycle while req_stall is low.
// The pick ripples combinationally through the row of NUM_TASKS cells.
// Reset (arst_n low) makes every task ready, clears all delays, selects task 0
// and zeroes the tick count; no clearing pass is needed afterwards.
// req_stall is high only while a result word is held and rsp_stall is high.
module tick_delay_task_scheduler_top
	import tdts_pkg::*;
#(
	parameter int unsigned NUM_TASKS = NUM_TASKS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	`include "assert_macros.svh"

	// Bits of tasks beyond NUM_TASKS are never touched and read as ready.
	localparam logic [SLOT_COUNT-1:0] ACTIVE_MASK = SLOT_COUNT'((1 << NUM_TASKS) - 1);

	logic                  accept;
	logic                  rsp_valid_q;
	rsp_t                  rsp_q;
	logic [TASK_W-1:0]     cur_q;
	logic [TICK_W-1:0]     tick_q;
	cell_ev_t              ev;
	logic [SLOT_COUNT:0]   taken;
	logic [SLOT_COUNT-1:0] hit;
	logic [SLOT_COUNT-1:0] ready_nxt;
	logic                  found;
	logic [TASK_W-1:0]     pick_idx;
	logic [TASK_W-1:0]     cur_d;

	// Hold input while a result word is stuck at the output.
	assign req_stall = rsp_valid_q & rsp_stall;
	assign accept    = req_valid & ~req_stall;

	// Decode the event into the controls broadcast to the cells.
	always_comb begin
		ev       = '0;
		ev.delay = req.delay_ticks;
		if (accept) begin
			unique case (req.kind)
				KIND_TICK:    ev.tick = 1'b1;
				KIND_SLEEP: begin
					ev.load  = 1'b1;
					ev.clear = 1'b1;
				end
				KIND_SUSPEND: ev.clear = 1'b1;
				KIND_PICK:    ev.pick  = (tick_q != '0);
				default:      ev       = '0;
			endcase
		end
	end

	// Row of task cells; the taken chain runs from task 0 upward.
	assign taken[0] = 1'b0;

	for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_slot
		if (i < NUM_TASKS) begin : g_cell
			tdts_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ev        (ev),
				.sel       (cur_q == TASK_W'(i)),
				.taken_in  (taken[i]),
				.taken_out (taken[i+1]),
				.hit       (hit[i]),
				.ready_nxt (ready_nxt[i])
			);
		end else begin : g_idle
			assign taken[i+1]   = taken[i];
			assign hit[i]       = 1'b0;
			assign ready_nxt[i] = 1'b1;
		end
	end

	// Turn the one-hot claim into a task number.
	always_comb begin
		pick_idx = '0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (hit[i]) begin
				pick_idx = pick_idx | TASK_W'(i);
			end
		end
	end

	assign found = |hit;
	assign cur_d = found ? pick_idx : cur_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q  <= '0;
			tick_q <= '0;
		end else begin
			cur_q <= cur_d;
			if (ev.tick) begin
				tick_q <= tick_q + TICK_W'(1);
			end
		end
	end

	// Output register: load on accept, drop once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q.chosen_task <= cur_d;
			rsp_q.task_found  <= found;
			rsp_q.ready_mask  <= ready_nxt;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`ASSERT_CLK(a_found_is_ready, rsp_valid && rsp.task_found |-> rsp.ready_mask[rsp.chosen_task], "picked task is not ready")
	`ASSERT_ALWAYS(a_hit_onehot, $onehot0(hit), "more than one cell claimed the pick")
	`ASSERT_CLK(a_idle_ready, rsp_valid |-> ((rsp.ready_mask | ACTIVE_MASK) == '1), "inactive task lost its ready bit")
	`ASSERT_CLK(a_cur_range, 32'(cur_q) < NUM_TASKS, "current task beyond task count")
	`ASSERT_CLK(a_accept_result, accept |=> rsp_valid, "accepted event gave no result word")

endmodule

// ----- rtl/core/tdts_cell.sv -----
module tdts_cell
	import tdts_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  cell_ev_t ev,
	input  logic     sel,
	input  logic     taken_in,
	output logic     taken_out,
	output logic     hit,
	output logic     ready_nxt
);

	logic               ready_q;
	logic [DELAY_W-1:0] cnt_q;
	logic [DELAY_W-1:0] cnt_d;

	always_comb begin
		cnt_d     = cnt_q;
		ready_nxt = ready_q;
		priority if (ev.tick) begin
			if (cnt_q != '0) begin
				cnt_d = cnt_q - DELAY_W'(1);
				if (cnt_q == DELAY_W'(1)) begin
					ready_nxt = 1'b1;
				end
			end
		end else if (sel) begin
			if (ev.load) begin
				cnt_d = ev.delay;
			end
			if (ev.clear) begin
				ready_nxt = 1'b0;
			end
		end
	end

	// Lowest ready cell claims the pick; pass the claim on to higher cells.
	assign hit       = ev.pick & ready_q & ~taken_in;
	assign taken_out = taken_in | ready_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q <= 1'b1;
			cnt_q   <= '0;
		end else begin
			ready_q <= ready_nxt;
			cnt_q   <= cnt_d;
		end
	end

endmodule
